### hdl/vfm_pkg.sv
// ----------------------------------------------------------------------------
// vfm_pkg
// Shared types and constants of the voxel face mesh extractor.
// ----------------------------------------------------------------------------
package vfm_pkg;

    localparam int COORD_W  = 5;
    localparam int CORNER_W = 7;
    localparam int NORMAL_W = 16;
    localparam int NV_W     = 8;   // summed normal component, |n| <= 77
    localparam int A2_W     = 13;  // square of one component
    localparam int SUMSQ_W  = 15;  // sum of three squares
    localparam int FACE_W   = 3;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    localparam logic [FACE_W-1:0] FACE_ZM  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_ZP  = 3'd1;
    localparam logic [FACE_W-1:0] FACE_YM  = 3'd2;
    localparam logic [FACE_W-1:0] FACE_YP  = 3'd3;
    localparam logic [FACE_W-1:0] FACE_XM  = 3'd4;
    localparam logic [FACE_W-1:0] FACE_XP  = 3'd5;
    localparam logic [FACE_W-1:0] FACE_END = 3'd6;

    // neighborhood row offsets, stored as offset + 2
    localparam logic [2:0] OFF_M1   = 3'd1;
    localparam logic [2:0] OFF_0    = 3'd2;
    localparam logic [2:0] OFF_P1   = 3'd3;
    localparam logic [2:0] OFF_LAST = 3'd4;

    // corner signs per face: bit2 x, bit1 y, bit0 z (1 = plus)
    localparam logic [2:0] CORNER_SIGNS [6][4] = '{
        '{3'd2, 3'd0, 3'd4, 3'd6},
        '{3'd7, 3'd5, 3'd1, 3'd3},
        '{3'd4, 3'd0, 3'd1, 3'd5},
        '{3'd7, 3'd3, 3'd2, 3'd6},
        '{3'd1, 3'd0, 3'd2, 3'd3},
        '{3'd7, 3'd6, 3'd4, 3'd5}
    };

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_GATHER,
        ST_FACE,
        ST_NORM,
        ST_EMIT,
        ST_EMPTY
    } vfm_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQ,
        N_LOAD,
        N_PREP,
        N_DIV,
        N_SQRT,
        N_STORE
    } nrm_state_t;

    typedef struct packed {
        logic            start;
        logic [NV_W-1:0] nx;
        logic [NV_W-1:0] ny;
        logic [NV_W-1:0] nz;
    } nrm_req_t;

    typedef struct packed {
        logic                done;
        logic [NORMAL_W-1:0] qx;
        logic [NORMAL_W-1:0] qy;
        logic [NORMAL_W-1:0] qz;
    } nrm_rsp_t;

endpackage

### hdl/vfm_ram.sv
// ----------------------------------------------------------------------------
// vfm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/vfm_norm.sv
// ----------------------------------------------------------------------------
// vfm_norm
// Iterative normalizer: per component, restoring divide of a^2*4*2^2F by
// the sum of squares, then a digit-by-digit square root, then rounding.
// ----------------------------------------------------------------------------
module vfm_norm #(
    parameter int FRAC_BITS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  vfm_pkg::nrm_req_t  req,
    output vfm_pkg::nrm_rsp_t  rsp
);

    localparam int NV_W  = vfm_pkg::NV_W;
    localparam int NRM_W = vfm_pkg::NORMAL_W;
    localparam int QW    = 2 * FRAC_BITS + 3;   // quotient bits
    localparam int RW    = FRAC_BITS + 2;       // root bits
    localparam int VW    = 2 * RW;              // radicand bits
    localparam int SW    = RW + 2;              // root remainder bits
    localparam int REMW  = vfm_pkg::SUMSQ_W + 1;
    localparam int CNT_W = $clog2(QW + 1);

    vfm_pkg::nrm_state_t state_reg, state_next;

    logic [1:0]                 comp_reg, comp_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [NV_W-1:0]            nvec_reg [3];
    logic [NV_W-1:0]            nvec_next [3];
    logic [vfm_pkg::SUMSQ_W-1:0] s_reg, s_next;
    logic [vfm_pkg::A2_W-1:0]   a2_reg, a2_next;
    logic [REMW-1:0]            rem_reg, rem_next;
    logic [QW-1:0]              dvd_reg, dvd_next;
    logic [VW-1:0]              vsh_reg, vsh_next;
    logic [RW-1:0]              root_reg, root_next;
    logic [SW-1:0]              srem_reg, srem_next;
    logic [NRM_W-1:0]           q_reg [3];
    logic [NRM_W-1:0]           q_next [3];
    logic                       done_reg, done_next;

    logic [NV_W-1:0]   ncur;
    logic [6:0]        acur;
    logic [13:0]       sq_full;
    logic [REMW-1:0]   r_sh;
    logic [REMW-1:0]   r_sub;
    logic              r_ge;
    logic [SW+1:0]     s_sh;
    logic [SW+1:0]     trial;
    logic [SW+1:0]     s_sub;
    logic              s_ge;
    logic [RW:0]       rnd;
    logic [RW+15:0]    q_ext;
    logic              sat;
    logic [14:0]       mag15;
    logic [NRM_W-1:0]  qval;

    always_comb begin
        ncur    = nvec_reg[comp_reg];
        acur    = 7'(ncur[NV_W-1] ? (~ncur + 1'b1) : ncur);
        sq_full = 14'(acur) * 14'(acur);

        r_sh  = {rem_reg[REMW-2:0], dvd_reg[QW-1]};
        r_ge  = r_sh >= REMW'(s_reg);
        r_sub = r_sh - REMW'(s_reg);

        s_sh  = {srem_reg, vsh_reg[VW-1:VW-2]};
        trial = (SW+2)'({root_reg, 2'b01});
        s_ge  = s_sh >= trial;
        s_sub = s_sh - trial;

        rnd   = (RW+1)'(root_reg) + (RW+1)'(1);
        q_ext = (RW+16)'(rnd[RW:1]);
        sat   = |q_ext[RW+15:15];
        mag15 = sat ? 15'h7FFF : q_ext[14:0];
        qval  = ncur[NV_W-1] ? (~{1'b0, mag15} + 1'b1) : {1'b0, mag15};
    end

    always_comb begin
        state_next = state_reg;
        comp_next  = comp_reg;
        cnt_next   = cnt_reg;
        nvec_next  = nvec_reg;
        s_next     = s_reg;
        a2_next    = a2_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        vsh_next   = vsh_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        q_next     = q_reg;
        done_next  = 1'b0;

        case (state_reg)
            vfm_pkg::N_IDLE: begin
                if (req.start) begin
                    nvec_next[0] = req.nx;
                    nvec_next[1] = req.ny;
                    nvec_next[2] = req.nz;
                    comp_next    = 2'd0;
                    s_next       = '0;
                    state_next   = vfm_pkg::N_SQ;
                end
            end
            vfm_pkg::N_SQ: begin
                s_next = s_reg + vfm_pkg::SUMSQ_W'(sq_full);
                if (comp_reg == 2'd2) begin
                    comp_next  = 2'd0;
                    state_next = vfm_pkg::N_LOAD;
                end else begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            vfm_pkg::N_LOAD: begin
                a2_next = sq_full[vfm_pkg::A2_W-1:0];
                if (acur == 7'd0) begin
                    q_next[comp_reg] = '0;
                    if (comp_reg == 2'd2) begin
                        done_next  = 1'b1;
                        state_next = vfm_pkg::N_IDLE;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end else begin
                    state_next = vfm_pkg::N_PREP;
                end
            end
            vfm_pkg::N_PREP: begin
                rem_next   = REMW'(a2_reg >> 1);
                dvd_next   = {a2_reg[0], {(QW-1){1'b0}}};
                cnt_next   = '0;
                state_next = vfm_pkg::N_DIV;
            end
            vfm_pkg::N_DIV: begin
                rem_next = r_ge ? r_sub : r_sh;
                dvd_next = {dvd_reg[QW-2:0], r_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QW - 1)) begin
                    vsh_next   = VW'(dvd_next);
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = vfm_pkg::N_SQRT;
                end
            end
            vfm_pkg::N_SQRT: begin
                srem_next = SW'(s_ge ? s_sub : s_sh);
                root_next = {root_reg[RW-2:0], s_ge};
                vsh_next  = {vsh_reg[VW-3:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RW - 1)) begin
                    state_next = vfm_pkg::N_STORE;
                end
            end
            vfm_pkg::N_STORE: begin
                q_next[comp_reg] = qval;
                if (comp_reg == 2'd2) begin
                    done_next  = 1'b1;
                    state_next = vfm_pkg::N_IDLE;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = vfm_pkg::N_LOAD;
                end
            end
            default: begin
                state_next = vfm_pkg::N_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vfm_pkg::N_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        comp_reg <= comp_next;
        cnt_reg  <= cnt_next;
        nvec_reg <= nvec_next;
        s_reg    <= s_next;
        a2_reg   <= a2_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        vsh_reg  <= vsh_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
        q_reg    <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.qx   = q_reg[0];
    assign rsp.qy   = q_reg[1];
    assign rsp.qz   = q_reg[2];

endmodule

### hdl/voxel_face_mesh_extractor_top.sv
// ----------------------------------------------------------------------------
// voxel_face_mesh_extractor_top
// Occupancy grid with culled-face mesh extraction and smoothed normals.
//
// The grid lives in one RAM holding a whole x row per word (GRID_SIDE^2
// words of GRID_SIDE bits). After reset the block clears the RAM one row
// per cycle, all GRID_SIDE^2 rows, before s_ready first rises. A write
// transaction reads the row, modifies it and writes it back, and returns
// nothing. An extract transaction reads the 25 rows of the 5x5x5
// neighborhood, then for each visible face runs the shared normalizer (a
// bit-serial divider and square root per component) and emits four
// vertices, one per accepted m_ transaction. An extract of an empty voxel
// or one with no visible face returns a single result with vertex_valid
// low and last_of_run high. One transaction is in flight at a time;
// s_ready is high only while the block is idle.
// ----------------------------------------------------------------------------
module voxel_face_mesh_extractor_top #(
    parameter int GRID_SIDE        = 32,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [4:0]          s_vox_x,
    input  logic [4:0]          s_vox_y,
    input  logic [4:0]          s_vox_z,
    input  logic                s_solid_value,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_vertex_valid,
    output logic [2:0]          m_face_index,
    output logic signed [6:0]   m_corner_x2,
    output logic signed [6:0]   m_corner_y2,
    output logic signed [6:0]   m_corner_z2,
    output logic signed [15:0]  m_normal_x,
    output logic signed [15:0]  m_normal_y,
    output logic signed [15:0]  m_normal_z,
    output logic                m_last_of_run
);

    localparam int ROWS = GRID_SIDE * GRID_SIDE;
    localparam int AW   = $clog2(ROWS);
    localparam int PW   = GRID_SIDE + 4;
    localparam int NV_W = vfm_pkg::NV_W;
    localparam int CW   = vfm_pkg::COORD_W;

    vfm_pkg::vfm_state_t state_reg, state_next;

    // latched request
    logic [CW-1:0]   vx_reg, vx_next;
    logic [CW-1:0]   vy_reg, vy_next;
    logic [CW-1:0]   vz_reg, vz_next;
    logic            solid_reg, solid_next;

    // clearing sweep
    logic [AW-1:0]   clr_reg, clr_next;

    // neighborhood gather: issue side and capture side of the RAM read
    logic [2:0]      iss_y_reg, iss_y_next;
    logic [2:0]      iss_z_reg, iss_z_next;
    logic            iss_act_reg, iss_act_next;
    logic            cap_v_reg, cap_v_next;
    logic [2:0]      cap_y_reg, cap_y_next;
    logic [2:0]      cap_z_reg, cap_z_next;
    logic            cap_in_reg, cap_in_next;

    // negated summed offsets and face neighbor bits
    logic [NV_W-1:0] bx_reg, bx_next;
    logic [NV_W-1:0] by_reg, by_next;
    logic [NV_W-1:0] bz_reg, bz_next;
    logic [5:0]      nb_reg, nb_next;
    logic            ctr_reg, ctr_next;

    // face walk and emission
    logic [2:0]      face_reg, face_next;
    logic [1:0]      corner_reg, corner_next;
    logic            any_reg, any_next;
    logic [15:0]     qx_reg, qx_next;
    logic [15:0]     qy_reg, qy_next;
    logic [15:0]     qz_reg, qz_next;

    // RAM port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [GRID_SIDE-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [GRID_SIDE-1:0] ram_rdata;

    vfm_pkg::nrm_req_t nreq;
    vfm_pkg::nrm_rsp_t nrsp;

    // row address for the current offsets; the item's own row outside GATHER
    logic [2:0]           off_y, off_z;
    logic signed [8:0]    yy, zz;
    logic                 row_in;
    logic [AW-1:0]        row_addr;
    logic                 x_in;
    logic [PW-1:0]        padded;
    logic [PW-1:0]        shifted;
    logic [4:0]           win;
    logic [4:0]           w;
    logic [2:0]           cnt3;
    logic [NV_W-1:0]      sox, dyo, dzo, ty, tz;
    logic [5:0]           vis;
    logic [5:0]           vis_hi;
    logic                 face_vis;
    logic                 last_face;
    logic [GRID_SIDE-1:0] wmask;
    logic [2:0]           sg;
    logic [6:0]           cx_base, cy_base, cz_base;
    logic                 s_acc;

    always_comb begin
        off_y    = (state_reg == vfm_pkg::ST_GATHER) ? iss_y_reg : vfm_pkg::OFF_0;
        off_z    = (state_reg == vfm_pkg::ST_GATHER) ? iss_z_reg : vfm_pkg::OFF_0;
        yy       = $signed({4'b0, vy_reg}) + $signed({6'b0, off_y}) - 9'sd2;
        zz       = $signed({4'b0, vz_reg}) + $signed({6'b0, off_z}) - 9'sd2;
        row_in   = !yy[8] && (yy[7:0] < 8'(GRID_SIDE)) &&
                   !zz[8] && (zz[7:0] < 8'(GRID_SIDE));
        row_addr = row_in ? AW'(32'(zz[7:0]) * GRID_SIDE + 32'(yy[7:0])) : '0;
        x_in     = 8'(vx_reg) < 8'(GRID_SIDE);

        // window of five voxels x-2 .. x+2 out of the returned row
        padded   = {2'b00, ram_rdata, 2'b00};
        shifted  = padded >> vx_reg;
        win      = shifted[4:0];
        w        = cap_in_reg ? win : 5'b0;
        cnt3     = 3'(w[0]) + 3'(w[1]) + 3'(w[2]) + 3'(w[3]) + 3'(w[4]);
        sox      = (NV_W'({w[4], 1'b0}) + NV_W'(w[3])) -
                   (NV_W'({w[0], 1'b0}) + NV_W'(w[1]));
        dyo      = NV_W'(cap_y_reg) - NV_W'(2);
        dzo      = NV_W'(cap_z_reg) - NV_W'(2);
        ty       = NV_W'(cnt3) * dyo;
        tz       = NV_W'(cnt3) * dzo;

        vis       = ctr_reg ? ~nb_reg : 6'b0;
        vis_hi    = vis >> face_reg;
        face_vis  = (face_reg != vfm_pkg::FACE_END) && vis[face_reg];
        last_face = (vis_hi[5:1] == 5'b0);

        wmask     = GRID_SIDE'(1) << vx_reg;
        s_acc     = s_valid && s_ready;
    end

    // face normal: negated sum of occupied offsets, pushed by two along the face axis
    always_comb begin
        nreq.start = (state_reg == vfm_pkg::ST_FACE) && face_vis;
        nreq.nx    = bx_reg;
        nreq.ny    = by_reg;
        nreq.nz    = bz_reg;
        case (face_reg)
            vfm_pkg::FACE_ZM: nreq.nz = bz_reg - NV_W'(2);
            vfm_pkg::FACE_ZP: nreq.nz = bz_reg + NV_W'(2);
            vfm_pkg::FACE_YM: nreq.ny = by_reg - NV_W'(2);
            vfm_pkg::FACE_YP: nreq.ny = by_reg + NV_W'(2);
            vfm_pkg::FACE_XM: nreq.nx = bx_reg - NV_W'(2);
            vfm_pkg::FACE_XP: nreq.nx = bx_reg + NV_W'(2);
            default: ;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        vz_next      = vz_reg;
        solid_next   = solid_reg;
        clr_next     = clr_reg;
        iss_y_next   = iss_y_reg;
        iss_z_next   = iss_z_reg;
        iss_act_next = iss_act_reg;
        cap_v_next   = 1'b0;
        cap_y_next   = cap_y_reg;
        cap_z_next   = cap_z_reg;
        cap_in_next  = cap_in_reg;
        bx_next      = bx_reg;
        by_next      = by_reg;
        bz_next      = bz_reg;
        nb_next      = nb_reg;
        ctr_next     = ctr_reg;
        face_next    = face_reg;
        corner_next  = corner_reg;
        any_next     = any_reg;
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        qz_next      = qz_reg;

        ram_we    = 1'b0;
        ram_waddr = row_addr;
        ram_wdata = solid_reg ? (ram_rdata | wmask) : (ram_rdata & ~wmask);
        ram_raddr = row_addr;

        s_ready = 1'b0;

        case (state_reg)
            vfm_pkg::ST_CLEAR: begin
                // sweep every row to empty
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(ROWS - 1)) begin
                    state_next = vfm_pkg::ST_IDLE;
                end
            end
            vfm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_acc) begin
                    vx_next    = s_vox_x;
                    vy_next    = s_vox_y;
                    vz_next    = s_vox_z;
                    solid_next = s_solid_value;
                    if (s_req_type == vfm_pkg::REQ_WRITE) begin
                        state_next = vfm_pkg::ST_WR_RD;
                    end else begin
                        iss_y_next   = 3'd0;
                        iss_z_next   = 3'd0;
                        iss_act_next = 1'b1;
                        bx_next      = '0;
                        by_next      = '0;
                        bz_next      = '0;
                        nb_next      = '0;
                        ctr_next     = 1'b0;
                        state_next   = vfm_pkg::ST_GATHER;
                    end
                end
            end
            vfm_pkg::ST_WR_RD: begin
                // read the row; drop writes outside the grid
                state_next = (row_in && x_in) ? vfm_pkg::ST_WR_WB : vfm_pkg::ST_IDLE;
            end
            vfm_pkg::ST_WR_WB: begin
                ram_we     = 1'b1;
                state_next = vfm_pkg::ST_IDLE;
            end
            vfm_pkg::ST_GATHER: begin
                // issue one row read a cycle, fold in the row that came back
                if (iss_act_reg) begin
                    cap_v_next  = 1'b1;
                    cap_y_next  = iss_y_reg;
                    cap_z_next  = iss_z_reg;
                    cap_in_next = row_in;
                    if (iss_y_reg == vfm_pkg::OFF_LAST) begin
                        iss_y_next = 3'd0;
                        if (iss_z_reg == vfm_pkg::OFF_LAST) begin
                            iss_act_next = 1'b0;
                        end else begin
                            iss_z_next = iss_z_reg + 3'd1;
                        end
                    end else begin
                        iss_y_next = iss_y_reg + 3'd1;
                    end
                end
                if (cap_v_reg) begin
                    bx_next = bx_reg - sox;
                    by_next = by_reg - ty;
                    bz_next = bz_reg - tz;
                    if (cap_z_reg == vfm_pkg::OFF_0) begin
                        if (cap_y_reg == vfm_pkg::OFF_0) begin
                            ctr_next   = w[2];
                            nb_next[4] = w[1];
                            nb_next[5] = w[3];
                        end else if (cap_y_reg == vfm_pkg::OFF_M1) begin
                            nb_next[2] = w[2];
                        end else if (cap_y_reg == vfm_pkg::OFF_P1) begin
                            nb_next[3] = w[2];
                        end
                    end else if (cap_y_reg == vfm_pkg::OFF_0) begin
                        if (cap_z_reg == vfm_pkg::OFF_M1) begin
                            nb_next[0] = w[2];
                        end else if (cap_z_reg == vfm_pkg::OFF_P1) begin
                            nb_next[1] = w[2];
                        end
                    end
                end
                if (!iss_act_reg && !cap_v_reg) begin
                    face_next  = vfm_pkg::FACE_ZM;
                    any_next   = 1'b0;
                    state_next = vfm_pkg::ST_FACE;
                end
            end
            vfm_pkg::ST_FACE: begin
                // walk faces in order; start the normalizer on a visible one
                if (face_reg == vfm_pkg::FACE_END) begin
                    state_next = any_reg ? vfm_pkg::ST_IDLE : vfm_pkg::ST_EMPTY;
                end else if (face_vis) begin
                    state_next = vfm_pkg::ST_NORM;
                end else begin
                    face_next = face_reg + 3'd1;
                end
            end
            vfm_pkg::ST_NORM: begin
                if (nrsp.done) begin
                    qx_next     = nrsp.qx;
                    qy_next     = nrsp.qy;
                    qz_next     = nrsp.qz;
                    corner_next = 2'd0;
                    state_next  = vfm_pkg::ST_EMIT;
                end
            end
            vfm_pkg::ST_EMIT: begin
                if (m_ready) begin
                    any_next = 1'b1;
                    if (corner_reg == 2'd3) begin
                        face_next  = face_reg + 3'd1;
                        state_next = vfm_pkg::ST_FACE;
                    end else begin
                        corner_next = corner_reg + 2'd1;
                    end
                end
            end
            vfm_pkg::ST_EMPTY: begin
                if (m_ready) begin
                    state_next = vfm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vfm_pkg::ST_CLEAR;
            clr_reg     <= '0;
            iss_act_reg <= 1'b0;
            cap_v_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            iss_act_reg <= iss_act_next;
            cap_v_reg   <= cap_v_next;
        end
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        vz_reg     <= vz_next;
        solid_reg  <= solid_next;
        iss_y_reg  <= iss_y_next;
        iss_z_reg  <= iss_z_next;
        cap_y_reg  <= cap_y_next;
        cap_z_reg  <= cap_z_next;
        cap_in_reg <= cap_in_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        bz_reg     <= bz_next;
        nb_reg     <= nb_next;
        ctr_reg    <= ctr_next;
        face_reg   <= face_next;
        corner_reg <= corner_next;
        any_reg    <= any_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        qz_reg     <= qz_next;
    end

    vfm_ram #(
        .WIDTH (GRID_SIDE),
        .DEPTH (ROWS)
    ) u_grid (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vfm_norm #(
        .FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (nreq),
        .rsp     (nrsp)
    );

    // result payload, held steady by the registers behind it
    always_comb begin
        sg      = vfm_pkg::CORNER_SIGNS[face_reg][corner_reg];
        cx_base = {1'b0, vx_reg, 1'b0};
        cy_base = {1'b0, vy_reg, 1'b0};
        cz_base = {1'b0, vz_reg, 1'b0};

        m_valid        = (state_reg == vfm_pkg::ST_EMIT) || (state_reg == vfm_pkg::ST_EMPTY);
        m_vertex_valid = (state_reg == vfm_pkg::ST_EMIT);
        m_face_index   = '0;
        m_corner_x2    = '0;
        m_corner_y2    = '0;
        m_corner_z2    = '0;
        m_normal_x     = '0;
        m_normal_y     = '0;
        m_normal_z     = '0;
        m_last_of_run  = (state_reg == vfm_pkg::ST_EMPTY);
        if (state_reg == vfm_pkg::ST_EMIT) begin
            m_face_index  = face_reg;
            m_corner_x2   = $signed(sg[2] ? cx_base + 7'd1 : cx_base - 7'd1);
            m_corner_y2   = $signed(sg[1] ? cy_base + 7'd1 : cy_base - 7'd1);
            m_corner_z2   = $signed(sg[0] ? cz_base + 7'd1 : cz_base - 7'd1);
            m_normal_x    = $signed(qx_reg);
            m_normal_y    = $signed(qy_reg);
            m_normal_z    = $signed(qz_reg);
            m_last_of_run = (corner_reg == 2'd3) && last_face;
        end
    end

    // one transaction at a time: never ready for input while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input accepted while a result is pending");

    // an empty completion always closes its run
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_vertex_valid) |-> m_last_of_run)
        else $error("empty result without last_of_run");

    // the grid is never written while a neighborhood is being read
    a_no_write_gather: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vfm_pkg::ST_GATHER) |-> !ram_we)
        else $error("grid write during gather");

    // vertices only start once the normalizer has finished
    a_emit_after_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_vertex_valid)) |-> $past(nrsp.done))
        else $error("vertex emitted without a fresh normal");

endmodule
